// ===== rtl/fvn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvn_pkg: shared types and constants for the fractal value noise block
// Holds the sequencer states, the register indexes and the lattice constants.
// ----------------------------------------------------------------------------
package fvn_pkg;

    localparam int MAX_OCTAVES = 16;

    localparam logic [1:0] REG_OCTAVES  = 2'd0;
    localparam logic [1:0] REG_AMP      = 2'd1;
    localparam logic [1:0] REG_SCALE    = 2'd2;
    localparam logic [1:0] REG_PERSIST  = 2'd3;

    localparam logic [31:0] ONE_Q       = 32'h0001_0000;
    localparam logic [31:0] LAT_DIV     = 32'd3354521;
    localparam logic [31:0] HASH_MUL    = 32'h0000_4bd9;
    localparam logic [31:0] HASH_ADD0   = 32'h0002_e59b;
    localparam logic [31:0] HASH_ADD1   = 32'h004b_cb4b;
    localparam logic [31:0] HASH_MASK   = 32'h004b_746f;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PX,
        ST_PY,
        ST_CELL,
        ST_EX1,
        ST_EX2,
        ST_EY1,
        ST_EY2,
        ST_LAT_SEED,
        ST_LAT_H1,
        ST_LAT_H2,
        ST_LAT_H3,
        ST_LAT_DIV,
        ST_LAT_ACC,
        ST_CORNER,
        ST_LERP_T,
        ST_LERP_B,
        ST_LERP_V,
        ST_ACC1,
        ST_ACC2,
        ST_ACC3,
        ST_ADV1,
        ST_ADV2,
        ST_DONE
    } state_t;

    // Signed 33x33 multiplier request to the shared unit.
    typedef struct packed {
        logic signed [32:0] a;
        logic signed [32:0] b;
    } mul_req_t;

endpackage

// ===== rtl/fractal_value_noise_2d_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_value_noise_2d_top: multi-octave 2D value noise
// Sequencer driving one shared multiplier and one reciprocal divider.
// ----------------------------------------------------------------------------
// The result strobe follows the last octave. An octave takes longer in product mode than in sum
// mode, and longer still with smoothed corners; each lattice hash runs the seed, three hash
// steps, the divide and the accumulate. The last octave skips the scale and amplitude update.
// Throughput: one item at a time; busy stays high through the result strobe cycle,
// and the next start beat is taken in the cycle after it. The receiver cannot stall.
// Reset restores the register defaults and returns the sequencer to idle.
module fractal_value_noise_2d_top
#(
    parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic               smooth_select,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] base_amplitude,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic signed [31:0] noise_value,
    output logic               saturated
);

    localparam logic [5:0] MAXO = 6'(MAX_OCTAVES);

    // Configuration.
    logic [4:0]         oct_reg;
    logic signed [31:0] samp_reg, sscale_reg, pers_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg    <= 5'd4;
            samp_reg   <= 32'sd65536;
            sscale_reg <= 32'sd65536;
            pers_reg   <= 32'sd32768;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fvn_pkg::REG_OCTAVES: oct_reg    <= cfg_data[4:0];
                fvn_pkg::REG_AMP:     samp_reg   <= cfg_data;
                fvn_pkg::REG_SCALE:   sscale_reg <= cfg_data;
                fvn_pkg::REG_PERSIST: pers_reg   <= cfg_data;
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    // Shared units.
    fvn_pkg::mul_req_t  mreq;
    logic signed [65:0] prod;
    logic               dgo, ddone;
    logic [22:0]        dnum;
    logic [22:0]        dquot;

    fvn_mul u_mul (.clk(clk), .req(mreq), .prod(prod));
    fvn_div u_div (.clk(clk), .rst_n(rst_n), .go(dgo), .num(dnum),
                   .done(ddone), .quot(dquot));

    // Working registers.
    fvn_pkg::state_t    st_reg, st_next;
    logic               prod_md_reg, prod_md_next, sm_reg, sm_next;
    logic signed [31:0] x_reg, x_next, y_reg, y_next, base_reg, base_next;
    logic signed [31:0] amp_reg, amp_next, scl_reg, scl_next, val_reg, val_next;
    logic               flag_reg, flag_next;
    logic [4:0]         left_reg, left_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic [31:0]        gx_reg, gx_next, gy_reg, gy_next;
    logic signed [17:0] fx_reg, fx_next, fy_reg, fy_next;
    logic signed [35:0] ex_reg, ex_next, ey_reg, ey_next, tmp_reg, tmp_next;
    logic [1:0]         cn_reg, cn_next;
    logic [3:0]         nb_reg, nb_next;
    logic [31:0]        s_reg, s_next, h_reg, h_next;
    logic signed [23:0] lac_reg, lac_next;
    logic signed [19:0] c0_reg, c0_next, c1_reg, c1_next, c2_reg, c2_next;
    logic signed [19:0] c3_reg, c3_next, top_reg, top_next;
    logic signed [31:0] v_reg, v_next;
    logic               op_reg, op_next;

    // Floor shift by 16 and saturate.
    logic signed [49:0] pq;
    logic               p_hi, p_lo;
    logic signed [31:0] psat;
    assign pq   = 50'(prod >>> 16);
    assign p_hi = pq > 50'sd2147483647;
    assign p_lo = pq < -50'sd2147483648;
    assign psat = p_hi ? 32'sh7fffffff : (p_lo ? 32'sh80000000 : pq[31:0]);

    // Neighbour offsets of the smoothing kernel, and corner offsets.
    logic [31:0] lx, ly, dx, dy;
    logic [2:0]  lw;
    logic signed [19:0] lat_v;

    always_comb
    begin
        dx = {{31{1'b0}}, cn_reg[0]};
        dy = {{31{1'b0}}, cn_reg[1]};
        lx = gx_reg + dx;
        ly = gy_reg + dy;
        lw = 3'd1;
        if (sm_reg)
        begin
            case (nb_reg)
                4'd0: begin lx = lx - 32'd1; ly = ly - 32'd1; lw = 3'd1; end
                4'd1: begin                  ly = ly - 32'd1; lw = 3'd2; end
                4'd2: begin lx = lx + 32'd1; ly = ly - 32'd1; lw = 3'd1; end
                4'd3: begin lx = lx - 32'd1;                  lw = 3'd2; end
                4'd4: begin                                   lw = 3'd4; end
                4'd5: begin lx = lx + 32'd1;                  lw = 3'd2; end
                4'd6: begin lx = lx - 32'd1; ly = ly + 32'd1; lw = 3'd1; end
                4'd7: begin                  ly = ly + 32'd1; lw = 3'd2; end
                default: begin lx = lx + 32'd1; ly = ly + 32'd1; lw = 3'd1; end
            endcase
        end
    end

    assign lat_v = 20'sd65536 - $signed({1'b0, 19'(dquot)});

    logic signed [19:0] corner_v;
    logic signed [35:0] diff_x, diff_y;
    logic signed [33:0] addv;

    always_comb
    begin
        corner_v = sm_reg ? 20'(lac_reg >>> 4) : lac_reg[19:0];
        diff_x   = 36'(c1_reg) - 36'(c0_reg);
        diff_y   = 36'(c3_reg) - 36'(c2_reg);
        addv     = 34'(val_reg) + 34'(psat);
    end

    always_comb
    begin
        st_next = st_reg; prod_md_next = prod_md_reg; sm_next = sm_reg;
        x_next = x_reg; y_next = y_reg; base_next = base_reg;
        amp_next = amp_reg; scl_next = scl_reg; val_next = val_reg;
        flag_next = flag_reg; left_next = left_reg;
        px_next = px_reg; py_next = py_reg; gx_next = gx_reg; gy_next = gy_reg;
        fx_next = fx_reg; fy_next = fy_reg; ex_next = ex_reg; ey_next = ey_reg;
        tmp_next = tmp_reg; cn_next = cn_reg; nb_next = nb_reg;
        s_next = s_reg; h_next = h_reg; lac_next = lac_reg;
        c0_next = c0_reg; c1_next = c1_reg; c2_next = c2_reg; c3_next = c3_reg;
        top_next = top_reg; v_next = v_reg; op_next = op_reg;
        mreq.a = '0; mreq.b = '0;
        dgo = 1'b0; dnum = '0;

        case (st_reg)
            fvn_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    prod_md_next = req_type;
                    sm_next      = smooth_select;
                    x_next = coord_x; y_next = coord_y; base_next = base_amplitude;
                    amp_next = samp_reg; scl_next = sscale_reg;
                    val_next = req_type ? 32'sd65536 : 32'sd0;
                    flag_next = 1'b0;
                    if ({1'b0, oct_reg} > MAXO)
                        left_next = 5'(MAXO - 6'd1);
                    else if (oct_reg == 5'd0)
                        left_next = 5'd0;
                    else
                        left_next = oct_reg - 5'd1;
                    st_next = (left_next == 5'd0) ? fvn_pkg::ST_DONE : fvn_pkg::ST_PX;
                end
            end
            fvn_pkg::ST_PX:
            begin
                mreq.a = 33'(scl_reg); mreq.b = 33'(x_reg);
                st_next = fvn_pkg::ST_PY;
            end
            fvn_pkg::ST_PY:
            begin
                mreq.a = 33'(scl_reg); mreq.b = 33'(y_reg);
                px_next = psat; flag_next = flag_reg | p_hi | p_lo;
                st_next = fvn_pkg::ST_CELL;
            end
            fvn_pkg::ST_CELL:
            begin
                py_next = psat; flag_next = flag_reg | p_hi | p_lo;
                // Truncation toward zero of Q16.16.
                gx_next = 32'($signed(px_reg[31:16]) +
                    ((px_reg[31] && px_reg[15:0] != 16'd0) ? 17'sd1 : 17'sd0));
                gy_next = 32'($signed(psat[31:16]) +
                    ((psat[31] && psat[15:0] != 16'd0) ? 17'sd1 : 17'sd0));
                fx_next = (px_reg[31] && px_reg[15:0] != 16'd0) ?
                    18'($signed({1'b0, px_reg[15:0]}) - 18'sd65536) :
                    18'($signed({1'b0, px_reg[15:0]}));
                fy_next = (psat[31] && psat[15:0] != 16'd0) ?
                    18'($signed({1'b0, psat[15:0]}) - 18'sd65536) :
                    18'($signed({1'b0, psat[15:0]}));
                st_next = fvn_pkg::ST_EX1;
            end
            fvn_pkg::ST_EX1:
            begin
                mreq.a = 33'(fx_reg); mreq.b = 33'(fx_reg);
                st_next = fvn_pkg::ST_EX2;
            end
            fvn_pkg::ST_EX2:
            begin
                mreq.a = 33'(36'(prod >>> 16));
                mreq.b = 33'(20'sd196608 - 20'(fx_reg) - 20'(fx_reg));
                st_next = fvn_pkg::ST_EY1;
            end
            fvn_pkg::ST_EY1:
            begin
                ex_next = 36'(prod >>> 16);
                mreq.a = 33'(fy_reg); mreq.b = 33'(fy_reg);
                st_next = fvn_pkg::ST_EY2;
            end
            fvn_pkg::ST_EY2:
            begin
                mreq.a = 33'(36'(prod >>> 16));
                mreq.b = 33'(20'sd196608 - 20'(fy_reg) - 20'(fy_reg));
                cn_next = 2'd0; nb_next = 4'd0; lac_next = '0;
                st_next = fvn_pkg::ST_LAT_SEED;
            end
            fvn_pkg::ST_LAT_SEED:
            begin
                if (cn_reg == 2'd0 && nb_reg == 4'd0)
                    ey_next = 36'(prod >>> 16);
                s_next = lx + ly * 32'd57;
                s_next = s_next ^ (s_next << 13);
                st_next = fvn_pkg::ST_LAT_H1;
            end
            fvn_pkg::ST_LAT_H1:
            begin
                h_next = s_reg * s_reg;
                st_next = fvn_pkg::ST_LAT_H2;
            end
            fvn_pkg::ST_LAT_H2:
            begin
                h_next = h_reg * fvn_pkg::HASH_MUL + fvn_pkg::HASH_ADD0;
                st_next = fvn_pkg::ST_LAT_H3;
            end
            fvn_pkg::ST_LAT_H3:
            begin
                h_next = h_reg * s_reg + fvn_pkg::HASH_ADD1;
                st_next = fvn_pkg::ST_LAT_DIV;
            end
            fvn_pkg::ST_LAT_DIV:
            begin
                dgo  = 1'b1;
                dnum = h_reg[22:0] & fvn_pkg::HASH_MASK[22:0];
                st_next = fvn_pkg::ST_LAT_ACC;
            end
            fvn_pkg::ST_LAT_ACC:
            begin
                if (ddone)
                begin
                    lac_next = lac_reg + 24'(lat_v) * $signed({21'd0, lw});
                    if (!sm_reg || nb_reg == 4'd8)
                        st_next = fvn_pkg::ST_CORNER;
                    else
                    begin
                        nb_next = nb_reg + 4'd1;
                        st_next = fvn_pkg::ST_LAT_SEED;
                    end
                end
            end
            fvn_pkg::ST_CORNER:
            begin
                case (cn_reg)
                    2'd0: c0_next = corner_v;
                    2'd1: c1_next = corner_v;
                    2'd2: c2_next = corner_v;
                    default: c3_next = corner_v;
                endcase
                nb_next = 4'd0; lac_next = '0;
                cn_next = cn_reg + 2'd1;
                st_next = (cn_reg == 2'd3) ? fvn_pkg::ST_LERP_T : fvn_pkg::ST_LAT_SEED;
            end
            fvn_pkg::ST_LERP_T:
            begin
                mreq.a = 33'(diff_x); mreq.b = 33'(ex_reg);
                st_next = fvn_pkg::ST_LERP_B;
            end
            fvn_pkg::ST_LERP_B:
            begin
                top_next = 20'(36'(c0_reg) + 36'(prod >>> 16));
                mreq.a = 33'(diff_y); mreq.b = 33'(ex_reg);
                st_next = fvn_pkg::ST_LERP_V;
            end
            fvn_pkg::ST_LERP_V:
            begin
                tmp_next = 36'(36'(c2_reg) + 36'(prod >>> 16));
                mreq.a = 33'(36'(tmp_next) - 36'(top_reg)); mreq.b = 33'(ey_reg);
                op_next = 1'b0;
                st_next = fvn_pkg::ST_ACC1;
            end
            fvn_pkg::ST_ACC1:
            begin
                v_next = 32'(36'(top_reg) + 36'(prod >>> 16));
                if (prod_md_reg)
                begin
                    mreq.a = 33'(base_reg); mreq.b = 33'(v_next);
                    st_next = fvn_pkg::ST_ACC2;
                end
                else
                begin
                    mreq.a = 33'(v_next); mreq.b = 33'(amp_reg);
                    st_next = fvn_pkg::ST_ACC3;
                end
            end
            fvn_pkg::ST_ACC2:
            begin
                flag_next = flag_reg | p_hi | p_lo;
                mreq.a = 33'(psat); mreq.b = 33'(amp_reg);
                st_next = fvn_pkg::ST_ACC3;
            end
            fvn_pkg::ST_ACC3:
            begin
                flag_next = flag_reg | p_hi | p_lo;
                if (prod_md_reg && !op_reg)
                begin
                    mreq.a = 33'(val_reg); mreq.b = 33'(psat);
                    op_next = 1'b1;
                end
                else if (prod_md_reg)
                begin
                    val_next = psat;
                    st_next = fvn_pkg::ST_ADV1;
                end
                else
                begin
                    if (addv > 34'sd2147483647)
                    begin
                        val_next = 32'sh7fffffff; flag_next = 1'b1;
                    end
                    else if (addv < -34'sd2147483648)
                    begin
                        val_next = 32'sh80000000; flag_next = 1'b1;
                    end
                    else
                        val_next = addv[31:0];
                    st_next = fvn_pkg::ST_ADV1;
                end
            end
            fvn_pkg::ST_ADV1:
            begin
                left_next = left_reg - 5'd1;
                if (left_reg == 5'd1)
                    st_next = fvn_pkg::ST_DONE;
                else
                begin
                    if (scl_reg[31] != scl_reg[30])
                    begin
                        flag_next = 1'b1;
                        scl_next = scl_reg[31] ? 32'sh80000000 : 32'sh7fffffff;
                    end
                    else
                        scl_next = {scl_reg[30:0], 1'b0};
                    mreq.a = 33'(amp_reg); mreq.b = 33'(pers_reg);
                    st_next = fvn_pkg::ST_ADV2;
                end
            end
            fvn_pkg::ST_ADV2:
            begin
                amp_next = psat; flag_next = flag_reg | p_hi | p_lo;
                st_next = fvn_pkg::ST_PX;
            end
            fvn_pkg::ST_DONE:
            begin
                st_next = fvn_pkg::ST_IDLE;
            end
            default: st_next = fvn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= fvn_pkg::ST_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        prod_md_reg <= prod_md_next; sm_reg <= sm_next;
        x_reg <= x_next; y_reg <= y_next; base_reg <= base_next;
        amp_reg <= amp_next; scl_reg <= scl_next; val_reg <= val_next;
        flag_reg <= flag_next; left_reg <= left_next;
        px_reg <= px_next; py_reg <= py_next; gx_reg <= gx_next; gy_reg <= gy_next;
        fx_reg <= fx_next; fy_reg <= fy_next; ex_reg <= ex_next; ey_reg <= ey_next;
        tmp_reg <= tmp_next; cn_reg <= cn_next; nb_reg <= nb_next;
        s_reg <= s_next; h_reg <= h_next; lac_reg <= lac_next;
        c0_reg <= c0_next; c1_reg <= c1_next; c2_reg <= c2_next; c3_reg <= c3_next;
        top_reg <= top_next; v_reg <= v_next; op_reg <= op_next;
    end

    assign busy        = (st_reg != fvn_pkg::ST_IDLE);
    assign done        = (st_reg == fvn_pkg::ST_DONE);
    assign noise_value = val_reg;
    assign saturated   = flag_reg;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done without busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("no return to idle after done");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("start not taken");

endmodule

// ===== rtl/fvn_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvn_mul: shared registered multiplier
// One signed 33x33 product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module fvn_mul
(
    input  logic                clk,
    input  fvn_pkg::mul_req_t   req,
    output logic signed [65:0]  prod
);

    logic signed [65:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= req.a * req.b;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/fvn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvn_div: reciprocal divider for the lattice value
// Rounds num * 2^16 over the lattice constant via a registered estimate.
// ----------------------------------------------------------------------------
module fvn_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [22:0] num,
    output logic        done,
    output logic [22:0] quot
);

    // The reciprocal product lands at most two below the rounded quotient, and
    // the remainder left over from it picks the final value.
    localparam logic [26:0] RECIP  = 27'((64'd1 << 48) / 64'(fvn_pkg::LAT_DIV));
    localparam logic [39:0] DIV_W  = 40'(fvn_pkg::LAT_DIV);
    localparam logic [39:0] DIV2_W = DIV_W + DIV_W;
    localparam logic [39:0] HALF_W = 40'(fvn_pkg::LAT_DIV >> 1);

    logic        v1_reg, v2_reg, v3_reg;
    logic [22:0] m1_reg, m2_reg;
    logic [49:0] est_reg;
    logic [17:0] qe_reg;
    logic [39:0] rem_reg;
    logic [17:0] qe;
    logic [39:0] rem_next;
    logic [17:0] quot_fix;

    always_comb
    begin
        qe       = est_reg[49:32];
        rem_next = ({1'b0, m2_reg, 16'd0} + HALF_W) - ({22'd0, qe} * DIV_W);
        if (rem_reg >= DIV2_W)
        begin
            quot_fix = qe_reg + 18'd2;
        end
        else if (rem_reg >= DIV_W)
        begin
            quot_fix = qe_reg + 18'd1;
        end
        else
        begin
            quot_fix = qe_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= go;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg  <= num;
        est_reg <= {27'd0, m1_reg} * {23'd0, RECIP};
        m2_reg  <= m1_reg;
        qe_reg  <= qe;
        rem_reg <= rem_next;
    end

    assign done = v3_reg;
    assign quot = {5'd0, quot_fix};

endmodule

// ===== tb/tb_fractal_value_noise_2d_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fractal_value_noise_2d_top: self-checking bench for the fractal noise block
// Drives noise requests and register writes through several octave, amplitude,
// scale and persistence settings. A bit-exact predictor queues the expected
// noise for each accepted request, and every result strobe is checked against
// the oldest entry in that queue.
// ----------------------------------------------------------------------------
module tb_fractal_value_noise_2d_top;

    localparam bit OP_SUM     = 1'b0;
    localparam bit OP_PRODUCT = 1'b1;

    typedef struct {
        bit [31:0] value;
        bit        clipped;
    } noise_t;

    class noise_scoreboard;
        noise_t    expected_q[$];
        int        errors;
        int        checked;
        bit [4:0]  octave_reg;
        int        amp_reg;
        int        scale_reg;
        int        persist_reg;

        function void reset_regs();
            octave_reg  = 5'd4;
            amp_reg     = 65536;
            scale_reg   = 65536;
            persist_reg = 32768;
        endfunction

        function void write_reg(logic [1:0] idx, bit [31:0] data);
            case (idx)
                fvn_pkg::REG_OCTAVES: octave_reg  = data[4:0];
                fvn_pkg::REG_AMP:     amp_reg     = data;
                fvn_pkg::REG_SCALE:   scale_reg   = data;
                fvn_pkg::REG_PERSIST: persist_reg = data;
                default: ;
            endcase
        endfunction

        function int clip32(longint v, inout bit flag);
            if (v > 64'sd2147483647) begin
                flag = 1'b1;
                return 32'sh7fff_ffff;
            end
            if (v < -64'sd2147483648) begin
                flag = 1'b1;
                return 32'sh8000_0000;
            end
            return int'(v);
        endfunction

        // Q16.16 product, floored, then clipped.
        function int fix_mul(int a, int b, inout bit flag);
            longint p;
            p = longint'(a) * longint'(b);
            return clip32(p >>> 16, flag);
        endfunction

        function longint lattice_val(bit [31:0] x, bit [31:0] y);
            bit [31:0] s;
            bit [31:0] h;
            bit [31:0] m;
            bit [63:0] q;
            s = x + y * 32'd57;
            s = s ^ (s << 13);
            h = (s * s * fvn_pkg::HASH_MUL + fvn_pkg::HASH_ADD0) * s + fvn_pkg::HASH_ADD1;
            m = h & fvn_pkg::HASH_MASK;
            q = ({32'd0, m} * 64'd65536 + {32'd0, fvn_pkg::LAT_DIV >> 1})
                / {32'd0, fvn_pkg::LAT_DIV};
            return 65536 - longint'(q);
        endfunction

        function longint corner_val(bit [31:0] x, bit [31:0] y, bit smooth);
            longint diag;
            longint side;
            if (!smooth)
                return lattice_val(x, y);
            diag = lattice_val(x - 1, y - 1) + lattice_val(x + 1, y - 1)
                 + lattice_val(x - 1, y + 1) + lattice_val(x + 1, y + 1);
            side = lattice_val(x - 1, y) + lattice_val(x + 1, y)
                 + lattice_val(x, y - 1) + lattice_val(x, y + 1);
            return (diag + 2 * side + 4 * lattice_val(x, y)) >>> 4;
        endfunction

        function longint ease(longint t);
            longint t2;
            t2 = (t * t) >>> 16;
            return (t2 * (3 * 65536 - 2 * t)) >>> 16;
        endfunction

        function longint blend(longint a, longint b, longint e);
            return a + (((b - a) * e) >>> 16);
        endfunction

        function int octave_noise(int px, int py, bit smooth);
            int        gx;
            int        gy;
            longint    ex;
            longint    ey;
            longint    top;
            longint    bot;
            bit [31:0] ux;
            bit [31:0] uy;
            gx  = px / 65536;
            gy  = py / 65536;
            ex  = ease(longint'(px) - longint'(gx) * 65536);
            ey  = ease(longint'(py) - longint'(gy) * 65536);
            ux  = gx;
            uy  = gy;
            top = blend(corner_val(ux, uy, smooth), corner_val(ux + 1, uy, smooth), ex);
            bot = blend(corner_val(ux, uy + 1, smooth),
                        corner_val(ux + 1, uy + 1, smooth), ex);
            return int'(blend(top, bot, ey));
        endfunction

        function void note_request(bit op, bit smooth, int x, int y, int base);
            noise_t e;
            bit     flag;
            int     n;
            int     octaves;
            int     amp;
            int     scale;
            int     acc;
            int     v;
            int     t;
            flag    = 1'b0;
            n       = (octave_reg > fvn_pkg::MAX_OCTAVES) ? fvn_pkg::MAX_OCTAVES : octave_reg;
            octaves = (n > 0) ? n - 1 : 0;
            amp     = amp_reg;
            scale   = scale_reg;
            acc     = (op == OP_PRODUCT) ? 65536 : 0;
            for (int i = 0; i < octaves; i++)
            begin
                v = octave_noise(fix_mul(scale, x, flag), fix_mul(scale, y, flag), smooth);
                if (op == OP_PRODUCT)
                begin
                    t   = fix_mul(fix_mul(base, v, flag), amp, flag);
                    acc = fix_mul(acc, t, flag);
                end
                else
                begin
                    t   = fix_mul(v, amp, flag);
                    acc = clip32(longint'(acc) + longint'(t), flag);
                end
                // The last octave leaves scale and amplitude alone.
                if (i + 1 < octaves)
                begin
                    scale = clip32(longint'(scale) * 2, flag);
                    amp   = fix_mul(amp, persist_reg, flag);
                end
            end
            e.value   = acc;
            e.clipped = flag;
            expected_q.push_back(e);
        endfunction

        task report(string what);
            $display("[%0t] error: %s", $realtime, what);
            errors++;
        endtask

        task check_result(bit [31:0] value, bit clipped);
            noise_t e;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result %h", value));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (value !== e.value)
                report($sformatf("noise_value %h, want %h", value, e.value));
            if (clipped !== e.clipped)
                report($sformatf("saturated %b, want %b", clipped, e.clipped));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic        smooth_select;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] base_amplitude;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        done;
    logic [31:0] noise_value;
    logic        saturated;

    noise_scoreboard sb;
    bit              idling_on;

    fractal_value_noise_2d_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .smooth_select  (smooth_select),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .base_amplitude (base_amplitude),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .noise_value    (noise_value),
        .saturated      (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(noise_value, saturated);
    end

    // Random idle burst between beats, most of the time none.
    task maybe_idle();
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
    endtask

    task send_request(bit op, bit smooth, bit [31:0] x, bit [31:0] y, bit [31:0] base);
        bit taken;
        taken          = 1'b0;
        req_type       = op;
        smooth_select  = smooth;
        coord_x        = x;
        coord_y        = y;
        base_amplitude = base;
        start          = 1'b1;
        while (!taken)
        begin
            @(posedge clk);
            if (!busy)
            begin
                taken = 1'b1;
                sb.note_request(op, smooth, x, y, base);
            end
        end
        @(negedge clk);
        start = 1'b0;
        maybe_idle();
    endtask

    task wait_drained();
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task write_register(logic [1:0] idx, bit [31:0] data);
        bit taken;
        taken     = 1'b0;
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        while (!taken)
        begin
            @(posedge clk);
            if (cfg_ready)
            begin
                taken = 1'b1;
                sb.write_reg(idx, data);
            end
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task set_config(bit [4:0] oct, bit [31:0] amp, bit [31:0] scale, bit [31:0] pers);
        wait_drained();
        write_register(fvn_pkg::REG_OCTAVES, {27'd0, oct});
        write_register(fvn_pkg::REG_AMP, amp);
        write_register(fvn_pkg::REG_SCALE, scale);
        write_register(fvn_pkg::REG_PERSIST, pers);
    endtask

    function bit [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    task random_requests(int count, int smooth_odds);
        for (int i = 0; i < count; i++)
        begin
            send_request($urandom_range(0, 1), $urandom_range(0, smooth_odds - 1) == 0,
                         rand_coord(), rand_coord(),
                         $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h0002_0000));
            // Let the pipe empty now and then so a request lands on an idle block.
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_regs();
        idling_on      = 1'b1;
        rst_n          = 1'b0;
        start          = 1'b0;
        req_type       = OP_SUM;
        smooth_select  = 1'b0;
        coord_x        = '0;
        coord_y        = '0;
        base_amplitude = '0;
        cfg_valid      = 1'b0;
        cfg_index      = fvn_pkg::REG_OCTAVES;
        cfg_data       = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed corners under the reset settings.
        send_request(OP_SUM,     1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        send_request(OP_PRODUCT, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        send_request(OP_SUM,     1'b1, 32'h0001_8000, 32'h0002_4000, 32'h0000_0000);
        send_request(OP_PRODUCT, 1'b1, 32'hfffe_8000, 32'h0003_c000, 32'h0002_0000);
        send_request(OP_SUM,     1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_request(OP_PRODUCT, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_request(OP_PRODUCT, 1'b0, 32'hffff_ffff, 32'hffff_0000, 32'h7fff_ffff);
        send_request(OP_SUM,     1'b0, 32'h0000_ffff, 32'hffff_0001, 32'hffff_ffff);
        send_request(OP_PRODUCT, 1'b1, 32'hffff_ffff, 32'h0000_ffff, 32'h8000_0000);
        send_request(OP_SUM,     1'b1, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
        send_request(OP_PRODUCT, 1'b0, 32'h1234_5678, 32'hedcb_a987, 32'h0000_0000);
        send_request(OP_SUM,     1'b0, 32'hffff_8000, 32'hffff_4000, 32'h0001_0000);

        // No octave at all: empty sum and empty product.
        set_config(5'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_request(OP_SUM,     1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_request(OP_PRODUCT, 1'b1, 32'h8000_0000, 32'h0001_0000, 32'h8000_0000);
        set_config(5'd1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_request(OP_SUM,     1'b1, 32'h0003_0000, 32'hfff0_0000, 32'h0001_0000);
        send_request(OP_PRODUCT, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);

        // Hold off until the block is empty before the next request.
        wait_drained();

        set_config(5'd2, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000);
        random_requests(300, 8);
        set_config(5'd3, 32'h7fff_ffff, 32'h0000_1000, 32'h7fff_ffff);
        random_requests(200, 8);
        set_config(5'd4, $urandom(), $urandom(), $urandom());
        random_requests(200, 16);
        set_config(5'd16, 32'h0001_0000, 32'h0000_0100, 32'h0001_8000);
        random_requests(6, 20);
        // Settings above the octave limit are clamped.
        set_config(5'd31, 32'h0000_4000, 32'h0000_0010, 32'h0002_0000);
        random_requests(4, 40);
        set_config(5'd2, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
        random_requests(150, 8);

        set_config(5'd3, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000);
        idling_on = 1'b0;
        random_requests(170, 8);

        wait_drained();
        repeat (100) @(negedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #300_000_000;
        $display("timeout");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
